// ----- src/ordered_array_list_macros.svh -----
// Assertion macros used by the ordered array list top level.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

`ifndef SYNTHESIS
`define OAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered array list check failed");
`define OAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered array list check failed");
`else
`define OAL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/oal_pkg.sv -----
// Types and constants shared by the ordered array list modules.
package oal_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  typedef enum logic [2:0] {
    CMD_CLEAR      = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_ERASE      = 3'd6,
    CMD_FIND       = 3'd7
  } oal_cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } oal_status_t;

  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_UP,
    WALK_DOWN,
    WALK_FIND
  } oal_walk_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } oal_cnt_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK_UP,
    S_WALK_DOWN,
    S_SEARCH,
    S_PLACE,
    S_FINISH
  } oal_state_t;

  typedef struct packed {
    oal_cmd_t                      cmd;
    logic signed [DATA_WIDTH-1:0]  value;
    logic [CNT_W-1:0]              position;
  } oal_in_t;

  typedef struct packed {
    oal_status_t       status;
    logic [ADDR_W-1:0] found_index;
    logic [CNT_W-1:0]  count;
  } oal_out_t;

  typedef struct packed {
    logic        load;
    oal_walk_t   start;
    logic        step;
    logic        append;
    logic        place;
    oal_cnt_op_t cnt_op;
    logic        set_result;
    oal_status_t res_status;
    logic        set_found;
    logic        publish;
  } oal_ctl_t;

  typedef struct packed {
    oal_cmd_t cmd;
    logic     full;
    logic     empty;
    logic     pos_over;
    logic     pos_at_end;
    logic     walk_done;
    logic     match;
    logic     out_free;
  } oal_stat_t;

endpackage

// ----- src/oal_datapath.sv -----
// Datapath of the ordered array list: element store, count, walk engine and result register.
module oal_datapath (
  input  logic                clk,
  input  logic                rst,
  input  oal_pkg::oal_ctl_t   ctl,
  output oal_pkg::oal_stat_t  stat,
  input  oal_pkg::oal_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oal_pkg::oal_out_t   out_data
);
  import oal_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] value_r;
  logic [CNT_W-1:0]      pos_r;
  oal_cmd_t              cmd_r;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      rem;
  logic [ADDR_W-1:0]     ptr;
  logic                  pend;
  logic [ADDR_W-1:0]     pend_addr;
  oal_walk_t             walk_mode;
  oal_status_t           res_status;
  logic [ADDR_W-1:0]     res_found;
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [DATA_WIDTH-1:0] wd;

  always_comb begin
    we = 1'b0;
    wa = pend_addr;
    wd = rd_data;
    if (ctl.place) begin
      we = 1'b1;
      wa = pos_r[ADDR_W-1:0];
      wd = value_r;
    end else if (ctl.append) begin
      we = 1'b1;
      wa = count[ADDR_W-1:0];
      wd = value_r;
    end else if (ctl.step && pend && walk_mode != WALK_FIND) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_data.cmd;
      value_r <= in_data.value;
      if (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_POP_FRONT) begin
        pos_r <= '0;
      end else begin
        pos_r <= in_data.position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      walk_mode <= WALK_NONE;
      rem       <= '0;
    end else begin
      unique case (ctl.start)
        WALK_UP: begin
          walk_mode <= WALK_UP;
          ptr       <= ADDR_W'(count - CNT_W'(1));
          rem       <= count - pos_r;
          pend      <= 1'b0;
        end
        WALK_DOWN: begin
          walk_mode <= WALK_DOWN;
          ptr       <= ADDR_W'(pos_r + CNT_W'(1));
          rem       <= count - pos_r - CNT_W'(1);
          pend      <= 1'b0;
        end
        WALK_FIND: begin
          walk_mode <= WALK_FIND;
          ptr       <= '0;
          rem       <= count;
          pend      <= 1'b0;
        end
        default: begin
          if (ctl.step) begin
            if (rem != '0) begin
              pend <= 1'b1;
              rem  <= rem - CNT_W'(1);
              unique case (walk_mode)
                WALK_UP: begin
                  pend_addr <= ptr + ADDR_W'(1);
                  ptr       <= ptr - ADDR_W'(1);
                end
                WALK_DOWN: begin
                  pend_addr <= ptr - ADDR_W'(1);
                  ptr       <= ptr + ADDR_W'(1);
                end
                default: begin
                  pend_addr <= ptr;
                  ptr       <= ptr + ADDR_W'(1);
                end
              endcase
            end else begin
              pend <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.cnt_op)
        CNT_INC:  count <= count + CNT_W'(1);
        CNT_DEC:  count <= count - CNT_W'(1);
        CNT_ZERO: count <= '0;
        default:  count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_status <= ST_OK;
      res_found  <= '0;
    end else begin
      if (ctl.set_result) begin
        res_status <= ctl.res_status;
      end
      if (ctl.set_found) begin
        res_found <= pend_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_data.status      <= res_status;
      out_data.found_index <= res_found;
      out_data.count       <= count;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.full       = (count == CNT_W'(DEPTH));
  assign stat.empty      = (count == '0);
  assign stat.pos_over   = (pos_r > count);
  assign stat.pos_at_end = (pos_r >= count);
  assign stat.walk_done  = (rem == '0) && !pend;
  assign stat.match      = pend && (rd_data == value_r);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ----- src/oal_controller.sv -----
// Controller state machine of the ordered array list.
module oal_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oal_pkg::oal_stat_t  stat,
  output oal_pkg::oal_ctl_t   ctl
);
  import oal_pkg::*;

  oal_state_t state;
  oal_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.set_result = 1'b1;
        ctl.res_status = ST_OK;
        state_next     = S_FINISH;
        unique case (stat.cmd)
          CMD_CLEAR: begin
            ctl.cnt_op = CNT_ZERO;
          end
          CMD_PUSH_BACK: begin
            if (stat.full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.append = 1'b1;
              ctl.cnt_op = CNT_INC;
            end
          end
          CMD_PUSH_FRONT, CMD_INSERT: begin
            if (stat.full) begin
              ctl.res_status = ST_FULL;
            end else if (stat.pos_over) begin
              ctl.res_status = ST_BADPOS;
            end else begin
              ctl.start  = WALK_UP;
              state_next = S_WALK_UP;
            end
          end
          CMD_POP_BACK: begin
            if (stat.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.cnt_op = CNT_DEC;
            end
          end
          CMD_POP_FRONT, CMD_ERASE: begin
            if (stat.empty) begin
              ctl.res_status = ST_EMPTY;
            end else if (stat.pos_at_end) begin
              ctl.res_status = ST_BADPOS;
            end else begin
              ctl.start  = WALK_DOWN;
              state_next = S_WALK_DOWN;
            end
          end
          default: begin
            ctl.start  = WALK_FIND;
            state_next = S_SEARCH;
          end
        endcase
      end
      S_WALK_UP: begin
        if (stat.walk_done) begin
          state_next = S_PLACE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_PLACE: begin
        ctl.place  = 1'b1;
        ctl.cnt_op = CNT_INC;
        state_next = S_FINISH;
      end
      S_WALK_DOWN: begin
        if (stat.walk_done) begin
          ctl.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_SEARCH: begin
        if (stat.match) begin
          ctl.set_found  = 1'b1;
          ctl.set_result = 1'b1;
          ctl.res_status = ST_OK;
          state_next     = S_FINISH;
        end else if (stat.walk_done) begin
          ctl.set_result = 1'b1;
          ctl.res_status = ST_NOTFOUND;
          state_next     = S_FINISH;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ordered_array_list.sv -----
// Top level of the ordered array list: controller, datapath and checks.
// The block keeps an ordered list of up to DEPTH signed words and takes
// one command per input transfer on in_data (cmd, value, position) under
// in_valid/in_ready. Every command gives exactly one result transfer on
// out_data (status, found_index, count) under out_valid/out_ready.
// Commands are handled one at a time. Clear, push back, pop back and any
// command that fails go from the decide state straight to the finish
// state. Push front and insert first walk the elements from the end down
// to position up by one place and then place the value; pop front and
// erase walk the elements above position down by one place; find reads
// from index 0 until a match or the end of the list. The single port pair
// of the element store moves one element per cycle during a walk.
// The result sits in an output register, so the next command is taken
// while a result still waits for out_ready; a stalled receiver holds the
// block only when a second result is ready to be published.
// Reset empties the list at once; the element store itself is not cleared.
module ordered_array_list (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  oal_pkg::oal_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output oal_pkg::oal_out_t out_data
);
  import oal_pkg::*;

  `include "ordered_array_list_macros.svh"

  oal_ctl_t  ctl;
  oal_stat_t stat;

  oal_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  oal_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `OAL_ASSERT_IMPL(a_count_bound, clk, rst, out_valid, out_data.count <= CNT_W'(DEPTH))
  `OAL_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `OAL_ASSERT_IMPL(a_no_append_when_full, clk, rst, ctl.append, !stat.full)
  `OAL_ASSERT_IMPL(a_found_only_on_ok, clk, rst, out_valid && out_data.found_index != '0, out_data.status == ST_OK)

endmodule
